>>> hw/rtl/assert_macros.svh
// assertion macros shared by the predictor rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge, reset included
`define BHP_ASSERT(lbl, clk_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) prop) else $error(msg);

// property checked only while out of reset
`define BHP_ASSERT_RST(lbl, clk_s, rstn_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

`endif

>>> hw/rtl/bhp_pkg.sv
// types, constants and helper functions of the branch predictor
package bhp_pkg;

    // index lengths after clamping, up to the largest table width
    localparam int LEN_W = 5;
    typedef logic [LEN_W-1:0] len_t;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 4;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MODE         = 3'd0,
        CFG_BIMODAL_BITS = 3'd1,
        CFG_GSHARE_BITS  = 3'd2,
        CFG_HISTORY_BITS = 3'd3,
        CFG_CHOOSER_BITS = 3'd4
    } cfg_idx_t;

    // predictor modes, the unused code behaves as hybrid
    typedef enum logic [1:0] {
        MODE_BIMODAL = 2'd0,
        MODE_GSHARE  = 2'd1,
        MODE_HYBRID  = 2'd2
    } mode_t;

    // register reset values
    localparam logic [1:0]            MODE_RST    = MODE_BIMODAL;
    localparam logic [CFG_DATA_W-1:0] TBL_LEN_RST = 4'd12;
    localparam logic [CFG_DATA_W-1:0] HIST_RST    = 4'd8;

    // 2-bit counter values
    localparam logic [1:0] CNT_MIN          = 2'd0;
    localparam logic [1:0] CNT_WEAK_BIMODAL = 2'd1;
    localparam logic [1:0] CNT_WEAK_TAKEN   = 2'd2;
    localparam logic [1:0] CNT_MAX          = 2'd3;

    // result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    localparam int TOTAL_W = 32;

    typedef struct packed {
        logic               predicted_taken;
        logic               mispredicted;
        logic               chose_gshare;
        logic [TOTAL_W-1:0] prediction_total;
        logic [TOTAL_W-1:0] mispredict_total;
    } result_t;

    // clamp a table length register to 1 .. maxv
    function automatic len_t clamp_len(input logic [CFG_DATA_W-1:0] v, input len_t maxv);
        len_t ext;
        ext = len_t'(v);
        if (ext == '0)
            return len_t'(1);
        else if (ext > maxv)
            return maxv;
        else
            return ext;
    endfunction

    // saturating 2-bit counter step
    function automatic logic [1:0] train(input logic [1:0] c, input logic up);
        if (up)
            return (c == CNT_MAX) ? CNT_MAX : c + 2'd1;
        else
            return (c == CNT_MIN) ? CNT_MIN : c - 2'd1;
    endfunction

endpackage

>>> hw/rtl/bhp_in_if.sv
// branch input channel: resolved branch address and outcome
interface bhp_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] branch_address;
    logic        branch_taken;

    modport source (output valid, output branch_address, output branch_taken, input ready);
    modport sink (input valid, input branch_address, input branch_taken, output ready);
endinterface

>>> hw/rtl/bhp_out_if.sv
// result output channel: prediction, miss flag, choice and running totals
interface bhp_out_if;
    logic        valid;
    logic        ready;
    logic        predicted_taken;
    logic        mispredicted;
    logic        chose_gshare;
    logic [31:0] prediction_total;
    logic [31:0] mispredict_total;

    modport source (output valid, output predicted_taken, output mispredicted,
                    output chose_gshare, output prediction_total,
                    output mispredict_total, input ready);
    modport sink (input valid, input predicted_taken, input mispredicted,
                  input chose_gshare, input prediction_total,
                  input mispredict_total, output ready);
endinterface

>>> hw/rtl/hybrid_branch_predictor_top.sv
// hybrid gshare / bimodal branch predictor top level
// Takes one resolved branch per cycle and returns one result per branch, in order:
// the prediction of the selected table before its update, a miss flag, which table
// was chosen and saturating totals. A branch is indexed and its three counter
// memories are read in the accept cycle; the next cycle trains the counters, writes
// back and queues the result. A write to an entry that the following branch reads
// is forwarded, which keeps the rate at one branch per cycle. The four-entry result
// queue absorbs output stalls; apart from the clearing pass, input ready drops only
// when it would overflow. After reset each counter memory runs a clearing pass over
// all its entries, during which no branch is accepted; configuration writes are
// taken at any time and should be made idle.
`include "assert_macros.svh"

module hybrid_branch_predictor_top #(
    parameter int BIMODAL_MAX_BITS = 12,
    parameter int GSHARE_MAX_BITS  = 12,
    parameter int CHOOSER_MAX_BITS = 12,
    parameter int COUNT_WIDTH      = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    bhp_in_if.sink                           branch_in,
    bhp_out_if.source                        result_out,
    input  logic                             cfg_we,
    input  logic [bhp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [bhp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int BW = BIMODAL_MAX_BITS;
    localparam int GW = GSHARE_MAX_BITS;
    localparam int CW = CHOOSER_MAX_BITS;

    // configuration registers
    logic [1:0]                      mode_reg;
    logic [bhp_pkg::CFG_DATA_W-1:0]  bim_len_reg;
    logic [bhp_pkg::CFG_DATA_W-1:0]  gsh_len_reg;
    logic [bhp_pkg::CFG_DATA_W-1:0]  hist_len_reg;
    logic [bhp_pkg::CFG_DATA_W-1:0]  cho_len_reg;

    // global history and totals
    logic [GW-1:0]          hist_reg;
    logic [GW-1:0]          hist_next;
    logic [COUNT_WIDTH-1:0] branch_cnt_reg;
    logic [COUNT_WIDTH-1:0] branch_cnt_next;
    logic [COUNT_WIDTH-1:0] miss_cnt_reg;
    logic [COUNT_WIDTH-1:0] miss_cnt_next;

    // update stage
    logic          s1_valid_reg;
    logic          s1_taken_reg;
    logic [BW-1:0] s1_bi_reg;
    logic [GW-1:0] s1_gi_reg;
    logic [CW-1:0] s1_ci_reg;

    // index path
    logic            in_acc;
    logic [29:0]     pc;
    bhp_pkg::len_t   mb;
    bhp_pkg::len_t   mg;
    bhp_pkg::len_t   mc;
    bhp_pkg::len_t   hlen;
    logic [BW-1:0]   bmask;
    logic [GW-1:0]   gmask;
    logic [CW-1:0]   cmask;
    logic [GW-1:0]   hmask;
    logic [GW-1:0]   hv;
    logic [GW-1:0]   hx;
    logic [BW-1:0]   bi;
    logic [GW-1:0]   gi;
    logic [CW-1:0]   ci;

    // table ports
    logic [1:0]  bim_rd;
    logic [1:0]  gsh_rd;
    logic [1:0]  cho_rd;
    logic        bim_we;
    logic        gsh_we;
    logic        cho_we;
    logic [1:0]  bim_wd;
    logic [1:0]  gsh_wd;
    logic [1:0]  cho_wd;
    logic        bim_busy;
    logic        gsh_busy;
    logic        cho_busy;

    // update logic
    logic              hybrid;
    logic              use_g;
    logic              bpred;
    logic              gpred;
    logic              pred;
    logic              miss;
    logic              bok;
    logic              gok;
    bhp_pkg::result_t  res;

    // queue
    logic                             q_pop;
    logic                             q_valid;
    bhp_pkg::result_t                 q_data;
    logic [bhp_pkg::QUEUE_CNT_W-1:0]  q_count;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= bhp_pkg::MODE_RST;
            bim_len_reg  <= bhp_pkg::TBL_LEN_RST;
            gsh_len_reg  <= bhp_pkg::TBL_LEN_RST;
            hist_len_reg <= bhp_pkg::HIST_RST;
            cho_len_reg  <= bhp_pkg::TBL_LEN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                bhp_pkg::CFG_MODE:         mode_reg     <= cfg_data[1:0];
                bhp_pkg::CFG_BIMODAL_BITS: bim_len_reg  <= cfg_data;
                bhp_pkg::CFG_GSHARE_BITS:  gsh_len_reg  <= cfg_data;
                bhp_pkg::CFG_HISTORY_BITS: hist_len_reg <= cfg_data;
                bhp_pkg::CFG_CHOOSER_BITS: cho_len_reg  <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // accept when no table is clearing and the queue has room for everything in flight
    assign in_acc = branch_in.valid && branch_in.ready;
    assign branch_in.ready = !(bim_busy || gsh_busy || cho_busy) &&
        ((int'(q_count) + int'(s1_valid_reg)) < bhp_pkg::QUEUE_DEPTH);

    // effective lengths
    assign pc   = branch_in.branch_address[31:2];
    assign mb   = bhp_pkg::clamp_len(bim_len_reg, bhp_pkg::len_t'(BW));
    assign mg   = bhp_pkg::clamp_len(gsh_len_reg, bhp_pkg::len_t'(GW));
    assign mc   = bhp_pkg::clamp_len(cho_len_reg, bhp_pkg::len_t'(CW));
    assign hlen = (bhp_pkg::len_t'(hist_len_reg) > mg) ? mg : bhp_pkg::len_t'(hist_len_reg);

    // index masks
    always_comb
    begin
        for (int i = 0; i < BW; i++)
            bmask[i] = (i < int'(mb));
        for (int i = 0; i < GW; i++)
            gmask[i] = (i < int'(mg));
        for (int i = 0; i < CW; i++)
            cmask[i] = (i < int'(mc));
        for (int i = 0; i < GW; i++)
            hmask[i] = ((i + int'(hlen)) >= GW);
    end

    // table indices, history folded into the top gshare index bits
    assign hv = hist_reg >> (bhp_pkg::len_t'(GW) - hlen);
    assign hx = GW'(hv << (mg - hlen));
    assign bi = pc[BW-1:0] & bmask;
    assign gi = (pc[GW-1:0] ^ hx) & gmask;
    assign ci = pc[CW-1:0] & cmask;

    // newest outcome enters the top history bit
    assign hist_next = ((hist_reg >> 1) | (GW'(branch_in.branch_taken) << (GW - 1))) & hmask;

    // counter memories
    bhp_table #(.AW(BW), .INIT(bhp_pkg::CNT_WEAK_TAKEN)) u_bim (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_acc),
        .rd_idx  (bi),
        .rd_data (bim_rd),
        .wr_en   (bim_we),
        .wr_idx  (s1_bi_reg),
        .wr_data (bim_wd),
        .busy    (bim_busy)
    );

    bhp_table #(.AW(GW), .INIT(bhp_pkg::CNT_WEAK_TAKEN)) u_gsh (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_acc),
        .rd_idx  (gi),
        .rd_data (gsh_rd),
        .wr_en   (gsh_we),
        .wr_idx  (s1_gi_reg),
        .wr_data (gsh_wd),
        .busy    (gsh_busy)
    );

    bhp_table #(.AW(CW), .INIT(bhp_pkg::CNT_WEAK_BIMODAL)) u_cho (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_acc),
        .rd_idx  (ci),
        .rd_data (cho_rd),
        .wr_en   (cho_we),
        .wr_idx  (s1_ci_reg),
        .wr_data (cho_wd),
        .busy    (cho_busy)
    );

    // stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            hist_reg       <= '0;
            branch_cnt_reg <= '0;
            miss_cnt_reg   <= '0;
        end
        else
        begin
            s1_valid_reg   <= in_acc;
            branch_cnt_reg <= branch_cnt_next;
            miss_cnt_reg   <= miss_cnt_next;
            if (in_acc)
                hist_reg <= hist_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_taken_reg <= branch_in.branch_taken;
            s1_bi_reg    <= bi;
            s1_gi_reg    <= gi;
            s1_ci_reg    <= ci;
        end
    end

    // prediction and table selection
    assign hybrid = (mode_reg != bhp_pkg::MODE_BIMODAL) && (mode_reg != bhp_pkg::MODE_GSHARE);
    assign bpred  = bim_rd[1];
    assign gpred  = gsh_rd[1];
    assign use_g  = (mode_reg == bhp_pkg::MODE_GSHARE) || (hybrid && cho_rd[1]);
    assign pred   = use_g ? gpred : bpred;
    assign miss   = pred != s1_taken_reg;
    assign bok    = bpred == s1_taken_reg;
    assign gok    = gpred == s1_taken_reg;

    // train only the chosen table
    assign bim_we = s1_valid_reg && !use_g;
    assign gsh_we = s1_valid_reg && use_g;
    assign bim_wd = bhp_pkg::train(bim_rd, s1_taken_reg);
    assign gsh_wd = bhp_pkg::train(gsh_rd, s1_taken_reg);

    // chooser moves toward the predictor that alone was right
    assign cho_we = s1_valid_reg && hybrid && (gok != bok);
    assign cho_wd = bhp_pkg::train(cho_rd, gok);

    // saturating totals
    always_comb
    begin
        branch_cnt_next = branch_cnt_reg;
        miss_cnt_next   = miss_cnt_reg;
        if (s1_valid_reg)
        begin
            if (!(&branch_cnt_reg))
                branch_cnt_next = branch_cnt_reg + 1'b1;
            if (miss && !(&miss_cnt_reg))
                miss_cnt_next = miss_cnt_reg + 1'b1;
        end
    end

    // result item
    assign res.predicted_taken  = pred;
    assign res.mispredicted     = miss;
    assign res.chose_gshare     = use_g;
    assign res.prediction_total = bhp_pkg::TOTAL_W'(branch_cnt_next);
    assign res.mispredict_total = bhp_pkg::TOTAL_W'(miss_cnt_next);

    bhp_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_valid_reg),
        .push_data (res),
        .pop       (q_pop),
        .out_valid (q_valid),
        .out_data  (q_data),
        .count     (q_count)
    );

    // output channel
    assign q_pop                       = q_valid && result_out.ready;
    assign result_out.valid            = q_valid;
    assign result_out.predicted_taken  = q_data.predicted_taken;
    assign result_out.mispredicted     = q_data.mispredicted;
    assign result_out.chose_gshare     = q_data.chose_gshare;
    assign result_out.prediction_total = q_data.prediction_total;
    assign result_out.mispredict_total = q_data.mispredict_total;

    // checks
    `BHP_ASSERT(a_queue_room, clk,
        !rst_n || ((int'(q_count) + int'(s1_valid_reg)) <= bhp_pkg::QUEUE_DEPTH),
        "result queue overflow")
    `BHP_ASSERT_RST(a_item_to_stage, clk, rst_n, in_acc |=> s1_valid_reg,
        "accepted item missing from update stage")
    `BHP_ASSERT_RST(a_result_queued, clk, rst_n,
        (s1_valid_reg && !q_pop) |=> (q_count == $past(q_count) + 1'b1),
        "result item not queued")

endmodule

>>> hw/rtl/bhp_table.sv
// 2-bit counter table: synchronous memory, clearing pass and write forwarding
module bhp_table #(
    parameter int         AW   = 12,
    parameter logic [1:0] INIT = 2'd2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_idx,
    output logic [1:0]    rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_idx,
    input  logic [1:0]    wr_data,
    output logic          busy
);

    localparam int DEPTH = 1 << AW;

    logic [1:0]    mem [DEPTH];
    logic [1:0]    rd_q_reg;
    logic [AW-1:0] rd_idx_reg;
    logic [AW-1:0] lw_idx_reg;
    logic [1:0]    lw_data_reg;

    logic          clr_busy_reg;
    logic          clr_busy_next;
    logic [AW-1:0] clr_idx_reg;
    logic [AW-1:0] clr_idx_next;
    logic          lw_valid_reg;
    logic          lw_valid_next;

    // clearing sweep after reset, one entry per cycle
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_idx_next  = clr_idx_reg;
        lw_valid_next = lw_valid_reg;
        if (clr_busy_reg)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == {AW{1'b1}})
                clr_busy_next = 1'b0;
        end
        else if (wr_en)
        begin
            lw_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_idx_reg  <= clr_idx_next;
            lw_valid_reg <= lw_valid_next;
        end
    end

    // memory array with registered read
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            mem[clr_idx_reg] <= INIT;
        else if (wr_en)
            mem[wr_idx] <= wr_data;
        if (rd_en)
        begin
            rd_q_reg   <= mem[rd_idx];
            rd_idx_reg <= rd_idx;
        end
        if (wr_en && !clr_busy_reg)
        begin
            lw_idx_reg  <= wr_idx;
            lw_data_reg <= wr_data;
        end
    end

    // a write in the same edge as the read is not seen by the array read
    assign rd_data = (lw_valid_reg && (lw_idx_reg == rd_idx_reg)) ? lw_data_reg : rd_q_reg;
    assign busy    = clr_busy_reg;

endmodule

>>> hw/rtl/bhp_out_queue.sv
// small result queue between the update stage and the output channel
module bhp_out_queue (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  bhp_pkg::result_t                 push_data,
    input  logic                             pop,
    output logic                             out_valid,
    output bhp_pkg::result_t                 out_data,
    output logic [bhp_pkg::QUEUE_CNT_W-1:0]  count
);

    bhp_pkg::result_t                 slots [bhp_pkg::QUEUE_DEPTH];
    logic [bhp_pkg::QUEUE_PTR_W-1:0]  wr_ptr_reg;
    logic [bhp_pkg::QUEUE_PTR_W-1:0]  wr_ptr_next;
    logic [bhp_pkg::QUEUE_PTR_W-1:0]  rd_ptr_reg;
    logic [bhp_pkg::QUEUE_PTR_W-1:0]  rd_ptr_next;
    logic [bhp_pkg::QUEUE_CNT_W-1:0]  count_reg;
    logic [bhp_pkg::QUEUE_CNT_W-1:0]  count_next;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_data;
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = slots[rd_ptr_reg];
    assign count     = count_reg;

endmodule

>>> test/bhp_result_checker.sv
// result checker: mirrors the predictor tables and compares every result item
module bhp_result_checker
    import bhp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    bhp_in_if                     branch_in,
    bhp_out_if                    result_out,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    outstanding
);

    localparam int IDX_MAX     = 12;
    localparam int TABLE_DEPTH = 1 << IDX_MAX;

    // mirrored predictor state
    logic [1:0]            bimodal_ctr [TABLE_DEPTH];
    logic [1:0]            gshare_ctr  [TABLE_DEPTH];
    logic [1:0]            chooser_ctr [TABLE_DEPTH];
    logic [IDX_MAX-1:0]    history;
    logic [TOTAL_W-1:0]    branch_total;
    logic [TOTAL_W-1:0]    miss_total;

    // mirrored registers
    logic [1:0]            mode_reg;
    logic [CFG_DATA_W-1:0] bim_len;
    logic [CFG_DATA_W-1:0] gsh_len;
    logic [CFG_DATA_W-1:0] hist_len;
    logic [CFG_DATA_W-1:0] cho_len;

    result_t expected_results[$];
    int      results_seen;

    // table length register to an index width of 1 .. IDX_MAX
    function automatic int unsigned fit_len(input logic [CFG_DATA_W-1:0] v);
        if (v == '0)
            return 1;
        if (int'(v) > IDX_MAX)
            return IDX_MAX;
        return int'(v);
    endfunction

    function automatic int unsigned low_ones(input int unsigned n);
        return (32'd1 << n) - 32'd1;
    endfunction

    // 2-bit saturating counter
    function automatic logic [1:0] step_ctr(input logic [1:0] c, input logic up);
        if (up && c != CNT_MAX)
            return c + 2'd1;
        if (!up && c != CNT_MIN)
            return c - 2'd1;
        return c;
    endfunction

    // predict one branch, train the tables and return the expected item
    function automatic result_t predict_branch(input logic [31:0] addr, input logic taken);
        int unsigned pc;
        int unsigned mb;
        int unsigned mg;
        int unsigned mc;
        int unsigned hl;
        int unsigned bi;
        int unsigned gi;
        int unsigned ci;
        int unsigned hv;
        int unsigned hnext;
        logic        bim_pred;
        logic        gsh_pred;
        logic        pick_g;
        logic        guess;
        logic        miss;
        result_t     r;

        pc = addr >> 2;
        mb = fit_len(bim_len);
        mg = fit_len(gsh_len);
        mc = fit_len(cho_len);
        hl = (int'(hist_len) > mg) ? mg : int'(hist_len);
        bi = pc & low_ones(mb);
        hv = int'(history) >> (IDX_MAX - hl);
        gi = ((pc & low_ones(mg)) ^ (hv << (mg - hl))) & low_ones(mg);
        ci = pc & low_ones(mc);

        bim_pred = bimodal_ctr[bi] >= CNT_WEAK_TAKEN;
        gsh_pred = gshare_ctr[gi] >= CNT_WEAK_TAKEN;

        // table selection, the spare mode code acts as hybrid
        case (mode_reg)
            MODE_BIMODAL: pick_g = 1'b0;
            MODE_GSHARE:  pick_g = 1'b1;
            default:      pick_g = chooser_ctr[ci] >= CNT_WEAK_TAKEN;
        endcase

        guess = pick_g ? gsh_pred : bim_pred;
        miss  = guess != taken;

        // only the chosen table learns
        if (pick_g)
            gshare_ctr[gi] = step_ctr(gshare_ctr[gi], taken);
        else
            bimodal_ctr[bi] = step_ctr(bimodal_ctr[bi], taken);

        // chooser leans toward the table that alone was right
        if (mode_reg != MODE_BIMODAL && mode_reg != MODE_GSHARE)
        begin
            if (gsh_pred == taken && bim_pred != taken)
                chooser_ctr[ci] = step_ctr(chooser_ctr[ci], 1'b1);
            else if (bim_pred == taken && gsh_pred != taken)
                chooser_ctr[ci] = step_ctr(chooser_ctr[ci], 1'b0);
        end

        // outcome enters the top of the history in every mode
        hnext = ((int'(history) >> 1) | (int'(taken) << (IDX_MAX - 1)))
                & (low_ones(hl) << (IDX_MAX - hl));
        history = hnext[IDX_MAX-1:0];

        if (branch_total != '1)
            branch_total = branch_total + 1'b1;
        if (miss && miss_total != '1)
            miss_total = miss_total + 1'b1;

        r.predicted_taken  = guess;
        r.mispredicted     = miss;
        r.chose_gshare     = pick_g;
        r.prediction_total = branch_total;
        r.mispredict_total = miss_total;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t, result %0d: %s", $time, results_seen, msg);
        mismatches++;
    endtask

    // compare one result item with the oldest expectation
    task automatic check_result(input result_t got);
        result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch("result item with no branch outstanding");
            return;
        end
        want = expected_results.pop_front();
        if (got.predicted_taken !== want.predicted_taken)
            report_mismatch($sformatf("predicted_taken %0b, expected %0b",
                                      got.predicted_taken, want.predicted_taken));
        if (got.mispredicted !== want.mispredicted)
            report_mismatch($sformatf("mispredicted %0b, expected %0b",
                                      got.mispredicted, want.mispredicted));
        if (got.chose_gshare !== want.chose_gshare)
            report_mismatch($sformatf("chose_gshare %0b, expected %0b",
                                      got.chose_gshare, want.chose_gshare));
        if (got.prediction_total !== want.prediction_total)
            report_mismatch($sformatf("prediction_total %0d, expected %0d",
                                      got.prediction_total, want.prediction_total));
        if (got.mispredict_total !== want.mispredict_total)
            report_mismatch($sformatf("mispredict_total %0d, expected %0d",
                                      got.mispredict_total, want.mispredict_total));
    endtask

    // track register writes, accepted branches and accepted results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                bimodal_ctr[i] = CNT_WEAK_TAKEN;
                gshare_ctr[i]  = CNT_WEAK_TAKEN;
                chooser_ctr[i] = CNT_WEAK_BIMODAL;
            end
            history      = '0;
            branch_total = '0;
            miss_total   = '0;
            mode_reg     = MODE_RST;
            bim_len      = TBL_LEN_RST;
            gsh_len      = TBL_LEN_RST;
            hist_len     = HIST_RST;
            cho_len      = TBL_LEN_RST;
            expected_results.delete();
            results_seen = 0;
            mismatches   = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_MODE:         mode_reg = cfg_data[1:0];
                    CFG_BIMODAL_BITS: bim_len  = cfg_data;
                    CFG_GSHARE_BITS:  gsh_len  = cfg_data;
                    CFG_HISTORY_BITS: hist_len = cfg_data;
                    CFG_CHOOSER_BITS: cho_len  = cfg_data;
                    default: ;
                endcase
            end
            if (result_out.valid && result_out.ready)
            begin
                check_result(result_t'{result_out.predicted_taken, result_out.mispredicted,
                                       result_out.chose_gshare, result_out.prediction_total,
                                       result_out.mispredict_total});
                results_seen++;
            end
            if (branch_in.valid && branch_in.ready)
                expected_results.push_back(predict_branch(branch_in.branch_address,
                                                          branch_in.branch_taken));
            outstanding <= expected_results.size();
        end
    end

endmodule

>>> test/tb.sv
// testbench top: clock, reset, branch and register stimulus, result stalls and verdict
module tb;
    import bhp_pkg::*;

    localparam int NUM_PHASES       = 8;
    localparam int ITEMS_PER_PHASE  = 122;
    localparam int DRAIN_CYCLES     = 8;
    localparam int HOLD_CYCLES      = 200;
    localparam int WATCHDOG_LIMIT   = 20000;
    localparam int HOT_BRANCHES     = 16;

    localparam logic [CFG_DATA_W-1:0] MODE_THREE   = 4'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = 3'd5;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int outstanding;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req_seq   = 0;
    int stuck_cycles   = 0;

    bhp_in_if  branch_ch ();
    bhp_out_if result_ch ();

    hybrid_branch_predictor_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .branch_in  (branch_ch),
        .result_out (result_ch),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data)
    );

    bhp_result_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .branch_in   (branch_ch),
        .result_out  (result_ch),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // give up when nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (branch_ch.valid && branch_ch.ready)
                   || (result_ch.valid && result_ch.ready))
            stuck_cycles <= 0;
        else if (stuck_cycles == WATCHDOG_LIMIT)
        begin
            $display("hybrid_branch_predictor_top test failed");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    // result side: random stalls plus long hold-offs on request
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_req_seq)
            begin
                hold_seen = hold_req_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // offer one branch item, with random idle cycles ahead of it
    task automatic send_branch(input logic [31:0] addr, input logic taken);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            branch_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        branch_ch.valid          <= 1'b1;
        branch_ch.branch_address <= addr;
        branch_ch.branch_taken   <= taken;
        do
            @(posedge clk);
        while (!branch_ch.ready);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results();
        branch_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write all five registers, then one index past the list
    task automatic write_registers(input logic [CFG_DATA_W-1:0] mode_val,
                                   input logic [CFG_DATA_W-1:0] bim_val,
                                   input logic [CFG_DATA_W-1:0] gsh_val,
                                   input logic [CFG_DATA_W-1:0] hist_val,
                                   input logic [CFG_DATA_W-1:0] cho_val);
        cfg_idx_t              reg_order [5];
        logic [CFG_DATA_W-1:0] reg_vals  [5];
        reg_order = '{CFG_MODE, CFG_BIMODAL_BITS, CFG_GSHARE_BITS,
                      CFG_HISTORY_BITS, CFG_CHOOSER_BITS};
        reg_vals  = '{mode_val, bim_val, gsh_val, hist_val, cho_val};
        for (int k = 0; k < 5; k++)
        begin
            cfg_we   <= 1'b1;
            cfg_addr <= reg_order[k];
            cfg_data <= reg_vals[k];
            @(posedge clk);
        end
        cfg_addr <= CFG_SPARE_LO + CFG_ADDR_W'($urandom_range(2));
        cfg_data <= CFG_DATA_W'($urandom_range(15));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // stimulus
    initial
    begin
        logic [31:0] hot_addr [HOT_BRANCHES];
        int          hot_bias [HOT_BRANCHES];
        logic [7:0]  alt_pattern;
        logic [31:0] addr;
        logic        taken;
        int          k;

        rst_n                    = 1'b0;
        cfg_we                   = 1'b0;
        cfg_addr                 = CFG_MODE;
        cfg_data                 = '0;
        branch_ch.valid          = 1'b0;
        branch_ch.branch_address = '0;
        branch_ch.branch_taken   = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, bimodal: counters saturate high and low, address extremes
        send_branch(32'h0000_0000, 1'b1);
        send_branch(32'h0000_0003, 1'b1);
        send_branch(32'h0000_0000, 1'b1);
        send_branch(32'hFFFF_FFFF, 1'b0);
        send_branch(32'hFFFF_FFFF, 1'b0);
        send_branch(32'hFFFF_FFFF, 1'b0);
        send_branch(32'hFFFF_FFFC, 1'b1);
        send_branch(32'h8000_0004, 1'b0);
        drain_results();

        // spare mode code acts as hybrid, zero widths act as one, oversized clamp
        write_registers(MODE_THREE, 4'd0, 4'd15, 4'd15, 4'd0);
        alt_pattern = 8'b1011_0010;
        for (k = 0; k < 8; k++)
            send_branch(32'h0000_1000, alt_pattern[k]);
        drain_results();

        // gshare with no history bits
        write_registers(CFG_DATA_W'(MODE_GSHARE), 4'd12, 4'd4, 4'd0, 4'd12);
        for (k = 0; k < 8; k++)
            send_branch(32'(k) << 4, k[0] ^ k[2]);
        drain_results();

        // random phases over several settings and idle profiles
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: write_registers(CFG_DATA_W'(MODE_HYBRID), 4'd12, 4'd12, 4'd12, 4'd12);
                1: write_registers(CFG_DATA_W'(MODE_HYBRID), 4'd1, 4'd1, 4'd1, 4'd1);
                2: write_registers(CFG_DATA_W'(MODE_GSHARE), 4'd15, 4'd12, 4'd12, 4'd15);
                3: write_registers(CFG_DATA_W'(MODE_BIMODAL), 4'd1, 4'd3, 4'd2, 4'd7);
                default: write_registers(CFG_DATA_W'($urandom_range(15)),
                                         CFG_DATA_W'($urandom_range(15)),
                                         CFG_DATA_W'($urandom_range(15)),
                                         CFG_DATA_W'($urandom_range(15)),
                                         CFG_DATA_W'($urandom_range(15)));
            endcase

            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 50; end
                default: begin send_idle_pct = 10; recv_stall_pct <= 10; end
            endcase

            // a small set of recurring branches, each with its own taken bias
            for (int h = 0; h < HOT_BRANCHES; h++)
            begin
                hot_addr[h] = $urandom;
                hot_bias[h] = $urandom_range(100);
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (p == 2 && n == 20)
                    hold_req_seq <= hold_req_seq + 1;
                if (p == 5 && n == 60)
                    drain_results();
                if ($urandom_range(99) < 15)
                begin
                    addr  = $urandom;
                    taken = 1'($urandom_range(1));
                end
                else
                begin
                    k     = $urandom_range(HOT_BRANCHES - 1);
                    addr  = hot_addr[k];
                    taken = $urandom_range(99) < hot_bias[k];
                end
                send_branch(addr, taken);
            end
            drain_results();
        end

        if (mismatches == 0)
            $display("hybrid_branch_predictor_top test passed");
        else
            $display("hybrid_branch_predictor_top test failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/bhp_pkg.sv
hw/rtl/bhp_in_if.sv
hw/rtl/bhp_out_if.sv
hw/rtl/bhp_table.sv
hw/rtl/bhp_out_queue.sv
hw/rtl/hybrid_branch_predictor_top.sv
test/bhp_result_checker.sv
test/tb.sv
